@@ rtl/ldim_pkg.sv @@
// Shared types and constants for the LED fade and blink dimmer.
`timescale 1ns / 1ps
`default_nettype none
package ldim_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_MAX_LEVEL    = 3'd0;
	localparam logic [2:0] REG_RISE_TIME    = 3'd1;
	localparam logic [2:0] REG_FALL_TIME    = 3'd2;
	localparam logic [2:0] REG_ON_TIME      = 3'd3;
	localparam logic [2:0] REG_BLINK_PERIOD = 3'd4;

	// Register values after reset.
	localparam logic [7:0]  RST_MAX_LEVEL    = 8'd255;
	localparam logic [15:0] RST_RISE_TIME    = 16'd250;
	localparam logic [15:0] RST_FALL_TIME    = 16'd250;
	localparam logic [15:0] RST_ON_TIME      = 16'd200;
	localparam logic [15:0] RST_BLINK_PERIOD = 16'd900;

	// Command codes; unused codes behave as a tick.
	localparam logic [2:0] FUNC_TICK    = 3'd0;
	localparam logic [2:0] FUNC_ON      = 3'd1;
	localparam logic [2:0] FUNC_OFF     = 3'd2;
	localparam logic [2:0] FUNC_BLINK   = 3'd3;
	localparam logic [2:0] FUNC_RESTART = 3'd4;

	// Phase codes as they appear on the result word.
	localparam logic [1:0] PH_OFF     = 2'd0;
	localparam logic [1:0] PH_RISING  = 2'd1;
	localparam logic [1:0] PH_ON      = 2'd2;
	localparam logic [1:0] PH_FALLING = 2'd3;

	// Input word.
	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] now_ms;
	} ldim_in_t;

	// Result word.
	typedef struct packed {
		logic [7:0] level;
		logic [1:0] phase;
	} ldim_out_t;

	// Configuration as seen by the sequencer, with derived blink values.
	typedef struct packed {
		logic [7:0]  max_level;
		logic [15:0] rise_time;
		logic [15:0] fall_time;
		logic [15:0] on_time;
		logic [15:0] off_gap;
		logic        blink_ok;
	} ldim_cfg_t;

endpackage
`default_nettype wire

@@ rtl/ldim_cfg_regs.sv @@
// Configuration registers of the dimmer and the blink values derived from them.
`timescale 1ns / 1ps
`default_nettype none
module ldim_cfg_regs (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_we,
	input  wire  [2:0]              cfg_index,
	input  wire  [15:0]             cfg_data,
	output ldim_pkg::ldim_cfg_t     cfg
);
	import ldim_pkg::*;

	logic [7:0]  max_level_q;
	logic [15:0] rise_time_q;
	logic [15:0] fall_time_q;
	logic [15:0] on_time_q;
	logic [15:0] blink_period_q;
	logic [15:0] off_gap_q;
	logic        blink_ok_q;
	logic [17:0] used_ms;

	// Register writes, decoded by index; other indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_level_q    <= RST_MAX_LEVEL;
			rise_time_q    <= RST_RISE_TIME;
			fall_time_q    <= RST_FALL_TIME;
			on_time_q      <= RST_ON_TIME;
			blink_period_q <= RST_BLINK_PERIOD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_LEVEL:    max_level_q    <= cfg_data[7:0];
				REG_RISE_TIME:    rise_time_q    <= cfg_data;
				REG_FALL_TIME:    fall_time_q    <= cfg_data;
				REG_ON_TIME:      on_time_q      <= cfg_data;
				REG_BLINK_PERIOD: blink_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Time used by rise, on and fall within one blink cycle.
	assign used_ms = {2'b00, on_time_q} + {2'b00, rise_time_q} + {2'b00, fall_time_q};

	// Off gap and blink permission follow the registers in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_gap_q  <= RST_BLINK_PERIOD - RST_ON_TIME - RST_RISE_TIME - RST_FALL_TIME;
			blink_ok_q <= 1'b1;
		end else begin
			blink_ok_q <= ({2'b00, blink_period_q} >= used_ms);
			if ({2'b00, blink_period_q} > used_ms) begin
				off_gap_q <= blink_period_q - used_ms[15:0];
			end else begin
				off_gap_q <= '0;
			end
		end
	end

	assign cfg.max_level = max_level_q;
	assign cfg.rise_time = rise_time_q;
	assign cfg.fall_time = fall_time_q;
	assign cfg.on_time   = on_time_q;
	assign cfg.off_gap   = off_gap_q;
	assign cfg.blink_ok  = blink_ok_q;

endmodule
`default_nettype wire

@@ rtl/ldim_div.sv @@
// Shared radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ldim_div (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [31:0] dividend,
	input  wire  [15:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  count_q;
	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] divisor_q;
	logic [16:0] rem_sh;
	logic [16:0] rem_diff;
	logic        fits;

	// One trial subtraction per cycle.
	assign rem_sh   = {rem_q, quo_q[31]};
	assign rem_diff = rem_sh - {1'b0, divisor_q};
	assign fits     = (rem_sh >= {1'b0, divisor_q});

	// Step control: 32 steps, then a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
			count_q <= '0;
		end else if (busy_q) begin
			count_q <= count_q + 5'd1;
			if (count_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder and dividend word, which fills with quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_diff[15:0] : rem_sh[15:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

@@ rtl/led_fade_blink_dimmer.sv @@
// Top level of the one-channel LED fade and blink dimmer with its sequencer.
//
//  channel   direction  signals                          word
//  item      in         item_valid, item_stall, item     func, now_ms
//  result    out        result_valid, result_stall, result  level, phase
//  config    in         cfg_we, cfg_index, cfg_data      register write
//
// Without a ramp division an item passes the command, advance and finish states; finish
// loads the output register. Each division by the shared restoring divider (one bit
// per cycle) adds the multiply and wait states; a reversal followed by a ramp update
// needs two. One item is worked on at a time; item_stall is high meanwhile.
// Reset is asynchronous and needs no clearing pass. A stalled result is held in
// the output register; the block then waits with the next result until it leaves.
`timescale 1ns / 1ps
`default_nettype none
module led_fade_blink_dimmer (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	output logic                 item_stall,
	input  ldim_pkg::ldim_in_t   item,
	output logic                 result_valid,
	input  wire                  result_stall,
	output ldim_pkg::ldim_out_t  result,
	input  wire                  cfg_we,
	input  wire  [2:0]           cfg_index,
	input  wire  [15:0]          cfg_data
);
	import ldim_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMD,
		ST_MUL,
		ST_DIV_WAIT,
		ST_ADV,
		ST_FIN
	} state_t;

	state_t      state_q;
	ldim_cfg_t   cfg;
	logic [2:0]  func_q;
	logic [31:0] now_q;
	logic [1:0]  phase_q;
	logic [31:0] next_event_q;
	logic        blink_q;
	logic [7:0]  level_q;
	logic [15:0] op_a_q;
	logic [15:0] op_b_q;
	logic [15:0] divisor_q;
	logic        lvl_mode_q;
	logic        result_valid_q;
	ldim_out_t   result_q;

	logic [15:0] span;
	logic        reached;
	logic [31:0] left_raw;
	logic [15:0] left_ms;
	logic [31:0] elapsed_raw;
	logic [15:0] elapsed_ms;
	logic [31:0] product;
	logic        div_start;
	logic        div_done;
	logic [31:0] div_quo;

	ldim_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Multiply feeds the divider, which registers the product at start.
	assign product   = op_a_q * op_b_q;
	assign div_start = (state_q == ST_MUL);

	ldim_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (divisor_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Ramp time of the current phase, time left and time elapsed on that ramp.
	assign span        = (phase_q == PH_FALLING) ? cfg.fall_time : cfg.rise_time;
	assign reached     = (now_q >= next_event_q);
	assign left_raw    = next_event_q - now_q;
	assign left_ms     = reached ? 16'd0 :
		((left_raw > {16'd0, span}) ? span : left_raw[15:0]);
	assign elapsed_raw = now_q - next_event_q + {16'd0, span};
	assign elapsed_ms  = (elapsed_raw > {16'd0, span}) ? span : elapsed_raw[15:0];

	// Sequencer: command, optional rescale divide, phase advance, optional level divide.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			func_q         <= FUNC_TICK;
			now_q          <= '0;
			phase_q        <= PH_OFF;
			next_event_q   <= '0;
			blink_q        <= 1'b0;
			level_q        <= '0;
			op_a_q         <= '0;
			op_b_q         <= '0;
			divisor_q      <= '0;
			lvl_mode_q     <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (result_valid_q && !result_stall && (state_q != ST_FIN)) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						func_q  <= item.func;
						now_q   <= item.now_ms;
						state_q <= ST_CMD;
					end
				end
				ST_CMD: begin
					state_q <= ST_ADV;
					case (func_q)
						FUNC_ON: begin
							blink_q <= 1'b0;
							if (phase_q == PH_OFF) begin
								next_event_q <= now_q + {16'd0, cfg.rise_time};
								phase_q      <= PH_RISING;
							end else if (phase_q == PH_FALLING) begin
								if (cfg.fall_time == 16'd0) begin
									next_event_q <= now_q;
									phase_q      <= PH_RISING;
								end else begin
									op_a_q     <= cfg.rise_time;
									op_b_q     <= left_ms;
									divisor_q  <= cfg.fall_time;
									lvl_mode_q <= 1'b0;
									state_q    <= ST_MUL;
								end
							end
						end
						FUNC_OFF: begin
							blink_q <= 1'b0;
							if (phase_q == PH_ON) begin
								next_event_q <= now_q + {16'd0, cfg.fall_time};
								phase_q      <= PH_FALLING;
							end else if (phase_q == PH_RISING) begin
								if (cfg.rise_time == 16'd0) begin
									next_event_q <= now_q;
									phase_q      <= PH_FALLING;
								end else begin
									op_a_q     <= cfg.fall_time;
									op_b_q     <= left_ms;
									divisor_q  <= cfg.rise_time;
									lvl_mode_q <= 1'b0;
									state_q    <= ST_MUL;
								end
							end
						end
						FUNC_BLINK: begin
							if (cfg.blink_ok) begin
								blink_q <= 1'b1;
							end
						end
						FUNC_RESTART: begin
							next_event_q <= now_q;
							phase_q      <= PH_RISING;
							blink_q      <= 1'b0;
						end
						default: ;
					endcase
				end
				ST_MUL: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						if (lvl_mode_q) begin
							if (phase_q == PH_RISING) begin
								level_q <= div_quo[7:0];
							end else begin
								level_q <= cfg.max_level - div_quo[7:0];
							end
							state_q <= ST_FIN;
						end else begin
							// Reversal: the rescaled remaining time sets the new deadline.
							next_event_q <= now_q + {16'd0, div_quo[15:0]};
							phase_q      <= (phase_q == PH_FALLING) ? PH_RISING : PH_FALLING;
							state_q      <= ST_ADV;
						end
					end
				end
				ST_ADV: begin
					state_q <= ST_FIN;
					case (phase_q)
						PH_OFF: begin
							if (blink_q && reached) begin
								next_event_q <= now_q + {16'd0, cfg.rise_time};
								phase_q      <= PH_RISING;
							end
						end
						PH_RISING: begin
							if (reached) begin
								level_q      <= cfg.max_level;
								next_event_q <= now_q + {16'd0, cfg.on_time};
								phase_q      <= PH_ON;
							end else if (cfg.rise_time == 16'd0) begin
								level_q <= cfg.max_level;
							end else begin
								op_a_q     <= {8'd0, cfg.max_level};
								op_b_q     <= elapsed_ms;
								divisor_q  <= cfg.rise_time;
								lvl_mode_q <= 1'b1;
								state_q    <= ST_MUL;
							end
						end
						PH_ON: begin
							if (blink_q && reached) begin
								next_event_q <= now_q + {16'd0, cfg.fall_time};
								phase_q      <= PH_FALLING;
							end
						end
						default: begin
							if (reached) begin
								level_q      <= '0;
								next_event_q <= now_q + {16'd0, cfg.off_gap};
								phase_q      <= PH_OFF;
							end else if (cfg.fall_time == 16'd0) begin
								level_q <= '0;
							end else begin
								op_a_q     <= {8'd0, cfg.max_level};
								op_b_q     <= elapsed_ms;
								divisor_q  <= cfg.fall_time;
								lvl_mode_q <= 1'b1;
								state_q    <= ST_MUL;
							end
						end
					endcase
				end
				ST_FIN: begin
					// Load the output register once it is free or being emptied.
					if (!result_valid_q || !result_stall) begin
						result_q.level <= level_q;
						result_q.phase <= phase_q;
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

@@ verif/led_fade_blink_dimmer_test.sv @@
// Self-checking testbench for the LED fade and blink dimmer with its own brightness predictor.
`timescale 1ns / 1ps
module led_fade_blink_dimmer_test;
	import ldim_pkg::*;

	// Command codes that the block treats as a plain tick.
	localparam logic [2:0] FUNC_SPARE_A = 3'd5;
	localparam logic [2:0] FUNC_SPARE_C = 3'd7;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int LATENCY_PAD   = 80;
	localparam int PHASE_WORDS   = 178;
	localparam int SETTING_COUNT = 8;
	localparam int HOLD_CYCLES   = 300;

	// One row of the directed part; fixed rows carry their expected word.
	typedef struct {
		logic [2:0]  func;
		logic [31:0] now;
		bit          fixed;
		logic [7:0]  level;
		logic [1:0]  phase;
	} plan_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_stall;
	ldim_in_t  item = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	ldim_out_t result;
	logic      cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_MAX_LEVEL;
	logic [15:0] cfg_data = '0;

	// Register copies and channel state of the predictor.
	logic [31:0] c_max = RST_MAX_LEVEL;
	logic [31:0] c_rise = RST_RISE_TIME;
	logic [31:0] c_fall = RST_FALL_TIME;
	logic [31:0] c_on = RST_ON_TIME;
	logic [31:0] c_period = RST_BLINK_PERIOD;
	logic [1:0]  ph_now = PH_OFF;
	logic [31:0] ev_ms = '0;
	bit          blinking = 1'b0;
	logic [31:0] lvl_now = '0;

	ldim_out_t brightness_due [$];
	int  words_sent = 0;
	int  words_checked = 0;
	int  fault_count = 0;
	int  cycle_count = 0;
	bit  calm = 1'b0;
	bit  hold_req = 1'b0;

	led_fade_blink_dimmer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("led_fade_blink_dimmer_test: errors");
			$finish;
		end
	end

	// Time left before the deadline, capped at the ramp length.
	function automatic logic [31:0] ms_left(input logic [31:0] now, input logic [31:0] span);
		logic [31:0] r;
		if (now >= ev_ms)
			return '0;
		r = ev_ms - now;
		return (r > span) ? span : r;
	endfunction

	// Time since the ramp began, capped at the ramp length.
	function automatic logic [31:0] ms_into(input logic [31:0] now, input logic [31:0] span);
		logic [31:0] e;
		e = now - (ev_ms - span);
		return (e > span) ? span : e;
	endfunction

	function automatic logic [31:0] scaled(input logic [31:0] rem, input logic [31:0] mul,
	                                       input logic [31:0] dv);
		if (dv == 0)
			return '0;
		return (mul * rem) / dv;
	endfunction

	function automatic logic [31:0] dark_gap();
		logic [31:0] used;
		used = c_on + c_rise + c_fall;
		return (c_period > used) ? c_period - used : '0;
	endfunction

	// Apply one command, advance the phase machine and return the new brightness word.
	function automatic ldim_out_t next_brightness(input logic [2:0] fn, input logic [31:0] now);
		ldim_out_t r;
		case (fn)
			FUNC_ON: begin
				if (ph_now == PH_OFF) begin
					ev_ms = now + c_rise;
					ph_now = PH_RISING;
				end else if (ph_now == PH_FALLING) begin
					ev_ms = now + scaled(ms_left(now, c_fall), c_rise, c_fall);
					ph_now = PH_RISING;
				end
				blinking = 1'b0;
			end
			FUNC_OFF: begin
				if (ph_now == PH_ON) begin
					ev_ms = now + c_fall;
					ph_now = PH_FALLING;
				end else if (ph_now == PH_RISING) begin
					ev_ms = now + scaled(ms_left(now, c_rise), c_fall, c_rise);
					ph_now = PH_FALLING;
				end
				blinking = 1'b0;
			end
			FUNC_BLINK: begin
				if (c_period >= c_rise + c_on + c_fall)
					blinking = 1'b1;
			end
			FUNC_RESTART: begin
				ev_ms = now;
				ph_now = PH_RISING;
				blinking = 1'b0;
			end
			default: ;
		endcase
		case (ph_now)
			PH_OFF: begin
				if (blinking && now >= ev_ms) begin
					ev_ms = now + c_rise;
					ph_now = PH_RISING;
				end
			end
			PH_RISING: begin
				if (now < ev_ms) begin
					lvl_now = (c_rise == 0) ? c_max : (c_max * ms_into(now, c_rise)) / c_rise;
				end else begin
					lvl_now = c_max;
					ev_ms = now + c_on;
					ph_now = PH_ON;
				end
			end
			PH_ON: begin
				if (blinking && now >= ev_ms) begin
					ev_ms = now + c_fall;
					ph_now = PH_FALLING;
				end
			end
			default: begin
				if (now < ev_ms) begin
					lvl_now = (c_fall == 0) ? '0 :
						c_max - (c_max * ms_into(now, c_fall)) / c_fall;
				end else begin
					lvl_now = '0;
					ph_now = PH_OFF;
					ev_ms = now + dark_gap();
				end
			end
		endcase
		lvl_now = lvl_now & 32'hFF;
		r.level = lvl_now[7:0];
		r.phase = ph_now;
		return r;
	endfunction

	// Result side: random stall bursts, one long hold-off, and the check of each word.
	always @(posedge clk) begin
		int        burst_left;
		int        hold_left;
		bit        hold_done;
		bit        stall_next;
		ldim_out_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (brightness_due.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("unexpected word: level %0d phase %0d",
						         result.level, result.phase);
				end else begin
					want = brightness_due.pop_front();
					words_checked++;
					if (result.level !== want.level || result.phase !== want.phase) begin
						fault_count++;
						if (fault_count <= 10)
							$display("word %0d: got level %0d phase %0d, expected level %0d phase %0d",
							         words_checked, result.level, result.phase,
							         want.level, want.phase);
					end
				end
			end
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (calm) begin
				stall_next = 1'b0;
			end else if (burst_left > 0) begin
				burst_left--;
				stall_next = 1'b1;
			end else if ($urandom_range(0, 5) == 0) begin
				burst_left = $urandom_range(0, 8);
				stall_next = 1'b1;
			end else begin
				stall_next = 1'b0;
			end
			result_stall <= stall_next;
		end
	end

	// Offer one word and hold it until the block takes it.
	task automatic offer(input logic [2:0] fn, input logic [31:0] now, input bit fixed,
	                     input ldim_out_t typed);
		ldim_out_t due;
		item_valid <= 1'b1;
		item <= {fn, now};
		do @(posedge clk); while (item_stall);
		due = next_brightness(fn, now);
		brightness_due.push_back(fixed ? typed : due);
		words_sent++;
	endtask

	// Lower valid and wait until every pending word has come back.
	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (brightness_due.size() != 0);
	endtask

	task automatic maybe_gap(input int odds);
		if (!calm && $urandom_range(0, odds - 1) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// Load all five registers while the block is idle.
	task automatic load_setting(input logic [15:0] mx, input logic [15:0] rs,
	                            input logic [15:0] fl, input logic [15:0] hold,
	                            input logic [15:0] per);
		logic [2:0]  idx [5];
		logic [15:0] val [5];
		idx = '{REG_MAX_LEVEL, REG_RISE_TIME, REG_FALL_TIME, REG_ON_TIME, REG_BLINK_PERIOD};
		val = '{mx, rs, fl, hold, per};
		drain();
		repeat (LATENCY_PAD) @(posedge clk);
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		c_max = {24'd0, mx[7:0]};
		c_rise = {16'd0, rs};
		c_fall = {16'd0, fl};
		c_on = {16'd0, hold};
		c_period = {16'd0, per};
		@(posedge clk);
	endtask

	// Random command mix: mostly ticks walking through the ramps.
	function automatic logic [2:0] pick_func();
		int r;
		r = $urandom_range(0, 99);
		if (r < 62)
			return FUNC_TICK;
		else if (r < 70)
			return FUNC_ON;
		else if (r < 78)
			return FUNC_OFF;
		else if (r < 88)
			return FUNC_BLINK;
		else if (r < 94)
			return FUNC_RESTART;
		else
			return FUNC_SPARE_A + 3'($urandom_range(0, FUNC_SPARE_C - FUNC_SPARE_A));
	endfunction

	// Stimulus, register settings and the verdict.
	initial begin
		plan_row_t   plan [0:23];
		logic [15:0] setting [0:SETTING_COUNT-1][0:4];
		logic [31:0] clock_ms;
		logic [31:0] span;
		logic [2:0]  fn;
		int          r;
		int          odds;

		plan = '{
			'{FUNC_TICK,    32'd0,          1'b1, 8'd0,   PH_OFF},
			'{FUNC_ON,      32'd1000,       1'b1, 8'd0,   PH_RISING},
			'{FUNC_TICK,    32'd1125,       1'b0, 8'd0,   PH_OFF},
			'{FUNC_TICK,    32'd1250,       1'b1, 8'd255, PH_ON},
			'{FUNC_OFF,     32'd1300,       1'b0, 8'd0,   PH_OFF},
			'{FUNC_ON,      32'd1400,       1'b0, 8'd0,   PH_OFF},
			'{FUNC_OFF,     32'd1450,       1'b0, 8'd0,   PH_OFF},
			'{FUNC_TICK,    32'd4000,       1'b1, 8'd0,   PH_OFF},
			'{FUNC_BLINK,   32'd4001,       1'b0, 8'd0,   PH_OFF},
			'{FUNC_TICK,    32'd4200,       1'b0, 8'd0,   PH_OFF},
			'{FUNC_TICK,    32'd4325,       1'b0, 8'd0,   PH_OFF},
			'{FUNC_TICK,    32'd4450,       1'b1, 8'd255, PH_ON},
			'{FUNC_TICK,    32'd4650,       1'b0, 8'd0,   PH_OFF},
			'{FUNC_TICK,    32'd4775,       1'b0, 8'd0,   PH_OFF},
			'{FUNC_TICK,    32'd4900,       1'b1, 8'd0,   PH_OFF},
			'{FUNC_SPARE_A, 32'd5000,       1'b0, 8'd0,   PH_OFF},
			'{FUNC_SPARE_A + 3'd1, 32'd5100, 1'b0, 8'd0,  PH_OFF},
			'{FUNC_SPARE_C, 32'd5200,       1'b0, 8'd0,   PH_OFF},
			'{FUNC_RESTART, 32'd5300,       1'b1, 8'd255, PH_ON},
			'{FUNC_RESTART, 32'hFFFF_FFFF,  1'b1, 8'd255, PH_ON},
			'{FUNC_OFF,     32'hFFFF_FFF0,  1'b0, 8'd0,   PH_OFF},
			'{FUNC_ON,      32'd0,          1'b1, 8'd0,   PH_RISING},
			'{FUNC_TICK,    32'h7FFF_FFFF,  1'b1, 8'd255, PH_ON},
			'{FUNC_BLINK,   32'h8000_0000,  1'b0, 8'd0,   PH_OFF}
		};

		// Settings in order; the first one cuts the blink period below the ramps
		// while blinking, and the seventh row is replaced by random values.
		setting = '{
			'{16'd255, 16'd250,   16'd250,   16'd200,   16'd0},
			'{16'd0,   16'd1,     16'd1,     16'd0,     16'd2},
			'{16'd255, 16'd65535, 16'd65535, 16'd65535, 16'd65535},
			'{16'd128, 16'd0,     16'd0,     16'd10,    16'd50},
			'{16'd200, 16'd300,   16'd100,   16'd50,    16'd1000},
			'{16'd17,  16'd7000,  16'd13,    16'd3,     16'd9000},
			'{16'd0,   16'd0,     16'd0,     16'd0,     16'd0},
			'{RST_MAX_LEVEL, RST_RISE_TIME, RST_FALL_TIME, RST_ON_TIME, RST_BLINK_PERIOD}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk through on, off, reversals, blink and time wrap.
		foreach (plan[i]) begin
			offer(plan[i].func, plan[i].now, plan[i].fixed, {plan[i].level, plan[i].phase});
			maybe_gap(4);
		end
		clock_ms = 32'h8000_0000;

		// Random words under each register setting.
		for (int p = 0; p < SETTING_COUNT; p++) begin
			if (p == 6)
				setting[p] = '{16'($urandom_range(0, 255)), 16'($urandom_range(1, 3000)),
				               16'($urandom_range(1, 3000)), 16'($urandom_range(0, 3000)),
				               16'($urandom_range(0, 12000))};
			load_setting(setting[p][0], setting[p][1], setting[p][2], setting[p][3],
			             setting[p][4]);
			calm = (p == SETTING_COUNT - 1);
			odds = (p % 2 == 0) ? 4 : 20;
			span = c_rise;
			if (c_fall > span)
				span = c_fall;
			if (c_on > span)
				span = c_on;
			if (dark_gap() > span)
				span = dark_gap();
			for (int k = 0; k < PHASE_WORDS; k++) begin
				fn = pick_func();
				r = $urandom_range(0, 99);
				if (r < 85)
					clock_ms = clock_ms + $urandom_range(0, span / 6 + 1);
				else if (r < 93)
					clock_ms = clock_ms;
				else if (r < 98)
					clock_ms = $urandom();
				else
					clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
				offer(fn, clock_ms, 1'b0, '0);
				// The result side freezes for a long stretch while words keep coming.
				if (p == 1 && k == 40)
					hold_req = 1'b1;
				if (p == 3 && k == 60)
					drain();
				else
					maybe_gap(odds);
			end
		end

		drain();
		repeat (LATENCY_PAD) @(posedge clk);
		$display("Sent %0d words under %0d register settings plus reset values;",
		         words_sent, SETTING_COUNT);
		$display("%0d result words compared, %0d faults.", words_checked, fault_count);
		if (fault_count == 0 && brightness_due.size() == 0)
			$display("led_fade_blink_dimmer_test: clean");
		else
			$display("led_fade_blink_dimmer_test: errors");
		$finish;
	end

endmodule
